// ===== src/twms_pkg.sv =====
// Shared types, codes and index helpers of the trigram word sampler.
`timescale 1ns / 1ps

package twms_pkg;

   // symbol alphabet: 26 letters plus the word boundary mark
   localparam int unsigned BOUNDARY_SYM = 26;
   localparam int unsigned SYMS         = BOUNDARY_SYM + 1;
   localparam int unsigned CTX_DEPTH    = SYMS * SYMS;
   localparam int unsigned TRI_DEPTH    = SYMS * SYMS * SYMS;
   localparam int unsigned CTX_AW       = $clog2(CTX_DEPTH);
   localparam int unsigned TRI_AW       = $clog2(TRI_DEPTH);

   localparam logic [4:0] SYM_BOUNDARY = 5'(BOUNDARY_SYM);

   // configuration register indexes
   localparam logic [1:0] CSR_MIN_LENGTH = 2'd0;
   localparam logic [1:0] CSR_MAX_LENGTH = 2'd1;
   localparam logic [1:0] CSR_MAX_TRIES  = 2'd2;

   localparam logic [3:0] MIN_LENGTH_RST = 4'd5;
   localparam logic [3:0] MAX_LENGTH_RST = 4'd9;
   localparam logic [3:0] MAX_TRIES_RST  = 4'd10;

   // request actions
   localparam logic [1:0] ACT_LEARN    = 2'd0;
   localparam logic [1:0] ACT_END_TEXT = 2'd1;
   localparam logic [1:0] ACT_START    = 2'd2;
   localparam logic [1:0] ACT_DRAW     = 2'd3;

   // response status codes
   localparam logic [2:0] STS_ACK       = 3'd0;
   localparam logic [2:0] STS_LETTER    = 3'd1;
   localparam logic [2:0] STS_COMPLETE  = 3'd2;
   localparam logic [2:0] STS_RETRY     = 3'd3;
   localparam logic [2:0] STS_RESTARTED = 3'd4;
   localparam logic [2:0] STS_EMPTY     = 3'd5;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_CNT_RD,
      ST_CNT_WR,
      ST_TOT_RD,
      ST_TOT_CHK,
      ST_DIV,
      ST_WALK,
      ST_APPLY,
      ST_FINISH
   } state_type;

   function automatic logic [CTX_AW-1:0] ctx_index(input logic [4:0] prev,
                                                   input logic [4:0] cur);
      return CTX_AW'(prev) * CTX_AW'(SYMS) + CTX_AW'(cur);
   endfunction

   function automatic logic [TRI_AW-1:0] tri_index(input logic [CTX_AW-1:0] ctx,
                                                   input logic [4:0] nxt);
      return TRI_AW'(ctx) * TRI_AW'(SYMS) + TRI_AW'(nxt);
   endfunction

   function automatic logic is_vowel(input logic [4:0] sym);
      return (sym == 5'd0) || (sym == 5'd4) || (sym == 5'd8) ||
             (sym == 5'd14) || (sym == 5'd20);
   endfunction

endpackage

// ===== src/trigram_word_model_sampler_top.sv =====
// Top level: trigram count store, learn path and word draw sequencer.
`timescale 1ns / 1ps
// Sequence: start word, end of text or a non-letter with no open word answer directly;
//   a letter, a word-closing byte or end of text read then write the counts; a draw reads the
//   row total, answers empty on zero, else runs a restoring modulo and walks the row to the symbol.
// Flow: one transaction in flight; the next request is taken in the cycle after the result
//   moves to the response register, which waits only while the previous response is stalled.
// Reset: synchronous; a clearing pass over every trigram entry follows with req_tready low; CSR any time.

module trigram_word_model_sampler_top #(
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [7:0] text_byte, [39:8] random_value
   input  logic [1:0]  req_tuser,   // [1:0] action
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [4:0] letter, [8:5] position, rest zero
   output logic [2:0]  rsp_tuser,   // [2:0] status
   // configuration
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_wdata
);

   localparam int unsigned CTX_AW = twms_pkg::CTX_AW;
   localparam int unsigned TRI_AW = twms_pkg::TRI_AW;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // ------------------------------------------------------------------
   // count memories: one trigram row of 27 counts per context, and the
   // row total per context (single port, registered read)
   // ------------------------------------------------------------------
   logic [COUNT_BITS-1:0] tri_mem [twms_pkg::TRI_DEPTH];
   logic [COUNT_BITS-1:0] tot_mem [twms_pkg::CTX_DEPTH];

   logic [TRI_AW-1:0]     tri_addr;
   logic                  tri_we;
   logic [COUNT_BITS-1:0] tri_wdata;
   logic [COUNT_BITS-1:0] tri_rd_ff;
   logic [CTX_AW-1:0]     tot_addr;
   logic                  tot_we;
   logic [COUNT_BITS-1:0] tot_wdata;
   logic [COUNT_BITS-1:0] tot_rd_ff;

   always_ff @(posedge clock) begin
      if (tri_we) begin
         tri_mem[tri_addr] <= tri_wdata;
      end
      tri_rd_ff <= tri_mem[tri_addr];
   end

   always_ff @(posedge clock) begin
      if (tot_we) begin
         tot_mem[tot_addr] <= tot_wdata;
      end
      tot_rd_ff <= tot_mem[tot_addr];
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   twms_pkg::state_type state_ff, state_in;

   logic [3:0]        min_len_ff, min_len_in;
   logic [3:0]        max_len_ff, max_len_in;
   logic [3:0]        max_tries_ff, max_tries_in;
   logic [4:0]        learn_prev_ff, learn_prev_in;
   logic [4:0]        learn_cur_ff, learn_cur_in;
   logic              in_word_ff, in_word_in;
   logic [4:0]        gen_prev_ff, gen_prev_in;
   logic [4:0]        gen_cur_ff, gen_cur_in;
   logic [3:0]        word_len_ff, word_len_in;
   logic [3:0]        vowel_cnt_ff, vowel_cnt_in;
   logic [3:0]        try_cnt_ff, try_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TRI_AW-1:0] clr_addr_ff, clr_addr_in;

   // payload
   logic [1:0]            act_ff, act_in;
   logic [7:0]            byte_ff, byte_in;
   logic [31:0]           rnd_ff, rnd_in;
   logic [CTX_AW-1:0]     ev_ctx_ff, ev_ctx_in;
   logic [TRI_AW-1:0]     ev_tri_ff, ev_tri_in;
   logic [COUNT_BITS-1:0] div_ff, div_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [4:0]            div_cnt_ff, div_cnt_in;
   logic [COUNT_BITS-1:0] acc_ff, acc_in;
   logic [4:0]            walk_k_ff, walk_k_in;
   logic [4:0]            chk_k_ff, chk_k_in;
   logic                  walk_vld_ff, walk_vld_in;
   logic [4:0]            sym_ff, sym_in;
   logic [2:0]            res_status_ff, res_status_in;
   logic [4:0]            res_letter_ff, res_letter_in;
   logic [3:0]            res_pos_ff, res_pos_in;
   logic [2:0]            rsp_status_ff, rsp_status_in;
   logic [4:0]            rsp_letter_ff, rsp_letter_in;
   logic [3:0]            rsp_pos_ff, rsp_pos_in;

   // ------------------------------------------------------------------
   // helpers
   // ------------------------------------------------------------------
   logic                  req_fire;
   logic [7:0]            byte_lc;
   logic                  byte_is_letter;
   logic [4:0]            byte_sym;
   logic [COUNT_BITS:0]   rem_shift;
   logic [COUNT_BITS:0]   acc_sum;
   logic                  walk_hit;
   logic                  rsp_free;
   logic [3:0]            try_next;

   assign req_tready = (state_ff == twms_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // case fold: letters only in 7-bit ASCII
   assign byte_lc        = byte_ff | 8'h20;
   assign byte_is_letter = !byte_ff[7] && (byte_lc >= 8'h61) && (byte_lc <= 8'h7a);
   assign byte_sym       = 5'(byte_lc - 8'h61);

   // restoring modulo step: one random bit a cycle, MSB first
   assign rem_shift = {rem_ff, rnd_ff[31]};

   // cumulative walk; the row adds up to the total, so the boundary
   // entry always ends the walk at the latest
   assign acc_sum  = {1'b0, acc_ff} + {1'b0, tri_rd_ff};
   assign walk_hit = (acc_sum > {1'b0, rem_ff}) || (chk_k_ff == twms_pkg::SYM_BOUNDARY);

   assign try_next = try_cnt_ff + 4'd1;

   // memory address and write muxes
   always_comb begin
      tri_addr  = ev_tri_ff;
      tri_we    = 1'b0;
      tri_wdata = tri_rd_ff + COUNT_BITS'(1);
      tot_addr  = ev_ctx_ff;
      tot_we    = 1'b0;
      tot_wdata = tot_rd_ff + COUNT_BITS'(1);
      case (state_ff)
         twms_pkg::ST_CLEAR: begin
            tri_addr  = clr_addr_ff;
            tri_we    = 1'b1;
            tri_wdata = '0;
            tot_addr  = clr_addr_ff[CTX_AW-1:0];
            tot_we    = (clr_addr_ff < TRI_AW'(twms_pkg::CTX_DEPTH));
            tot_wdata = '0;
         end
         twms_pkg::ST_CNT_WR: begin
            // saturated context drops the event
            tri_we = (tot_rd_ff != COUNT_MAX);
            tot_we = (tot_rd_ff != COUNT_MAX);
         end
         twms_pkg::ST_WALK: begin
            tri_addr = ev_tri_ff + TRI_AW'(walk_k_ff);
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // sequencer: next state and datapath
   // ------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      min_len_in    = min_len_ff;
      max_len_in    = max_len_ff;
      max_tries_in  = max_tries_ff;
      learn_prev_in = learn_prev_ff;
      learn_cur_in  = learn_cur_ff;
      in_word_in    = in_word_ff;
      gen_prev_in   = gen_prev_ff;
      gen_cur_in    = gen_cur_ff;
      word_len_in   = word_len_ff;
      vowel_cnt_in  = vowel_cnt_ff;
      try_cnt_in    = try_cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      clr_addr_in   = clr_addr_ff;
      act_in        = act_ff;
      byte_in       = byte_ff;
      rnd_in        = rnd_ff;
      ev_ctx_in     = ev_ctx_ff;
      ev_tri_in     = ev_tri_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      div_cnt_in    = div_cnt_ff;
      acc_in        = acc_ff;
      walk_k_in     = walk_k_ff;
      chk_k_in      = chk_k_ff;
      walk_vld_in   = walk_vld_ff;
      sym_in        = sym_ff;
      res_status_in = res_status_ff;
      res_letter_in = res_letter_ff;
      res_pos_in    = res_pos_ff;
      rsp_status_in = rsp_status_ff;
      rsp_letter_in = rsp_letter_ff;
      rsp_pos_in    = rsp_pos_ff;

      // response register drains independently of the sequencer
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         case (csr_index)
            twms_pkg::CSR_MIN_LENGTH: min_len_in   = csr_wdata;
            twms_pkg::CSR_MAX_LENGTH: max_len_in   = csr_wdata;
            twms_pkg::CSR_MAX_TRIES:  max_tries_in = csr_wdata;
            default: begin
            end
         endcase
      end

      case (state_ff)
         twms_pkg::ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + TRI_AW'(1);
            if (clr_addr_ff == TRI_AW'(twms_pkg::TRI_DEPTH - 1)) begin
               state_in = twms_pkg::ST_IDLE;
            end
         end

         twms_pkg::ST_IDLE: begin
            if (req_fire) begin
               act_in   = req_tuser;
               byte_in  = req_tdata[7:0];
               rnd_in   = req_tdata[39:8];
               state_in = twms_pkg::ST_EXEC;
            end
         end

         twms_pkg::ST_EXEC: begin
            res_status_in = twms_pkg::STS_ACK;
            res_letter_in = 5'd0;
            res_pos_in    = 4'd0;
            state_in      = twms_pkg::ST_FINISH;
            case (act_ff)
               twms_pkg::ACT_LEARN: begin
                  if (byte_is_letter) begin
                     // a new word starts from the boundary context
                     if (in_word_ff) begin
                        ev_ctx_in = twms_pkg::ctx_index(learn_prev_ff, learn_cur_ff);
                        ev_tri_in = twms_pkg::tri_index(
                           twms_pkg::ctx_index(learn_prev_ff, learn_cur_ff), byte_sym);
                        learn_prev_in = learn_cur_ff;
                     end else begin
                        ev_ctx_in = twms_pkg::ctx_index(twms_pkg::SYM_BOUNDARY,
                                                        twms_pkg::SYM_BOUNDARY);
                        ev_tri_in = twms_pkg::tri_index(
                           twms_pkg::ctx_index(twms_pkg::SYM_BOUNDARY,
                                               twms_pkg::SYM_BOUNDARY), byte_sym);
                        learn_prev_in = twms_pkg::SYM_BOUNDARY;
                     end
                     learn_cur_in = byte_sym;
                     in_word_in   = 1'b1;
                     state_in     = twms_pkg::ST_CNT_RD;
                  end else begin
                     // non-letter closes the word like end of text
                     ev_ctx_in = twms_pkg::ctx_index(learn_prev_ff, learn_cur_ff);
                     ev_tri_in = twms_pkg::tri_index(
                        twms_pkg::ctx_index(learn_prev_ff, learn_cur_ff),
                        twms_pkg::SYM_BOUNDARY);
                     learn_prev_in = twms_pkg::SYM_BOUNDARY;
                     learn_cur_in  = twms_pkg::SYM_BOUNDARY;
                     in_word_in    = 1'b0;
                     if (in_word_ff) begin
                        state_in = twms_pkg::ST_CNT_RD;
                     end
                  end
               end
               twms_pkg::ACT_END_TEXT: begin
                  ev_ctx_in = twms_pkg::ctx_index(learn_prev_ff, learn_cur_ff);
                  ev_tri_in = twms_pkg::tri_index(
                     twms_pkg::ctx_index(learn_prev_ff, learn_cur_ff),
                     twms_pkg::SYM_BOUNDARY);
                  learn_prev_in = twms_pkg::SYM_BOUNDARY;
                  learn_cur_in  = twms_pkg::SYM_BOUNDARY;
                  in_word_in    = 1'b0;
                  if (in_word_ff) begin
                     state_in = twms_pkg::ST_CNT_RD;
                  end
               end
               twms_pkg::ACT_START: begin
                  gen_prev_in  = twms_pkg::SYM_BOUNDARY;
                  gen_cur_in   = twms_pkg::SYM_BOUNDARY;
                  word_len_in  = 4'd0;
                  vowel_cnt_in = 4'd0;
                  try_cnt_in   = 4'd0;
               end
               twms_pkg::ACT_DRAW: begin
                  // row base of the draw context; the walk adds the symbol
                  ev_ctx_in = twms_pkg::ctx_index(gen_prev_ff, gen_cur_ff);
                  ev_tri_in = twms_pkg::tri_index(
                     twms_pkg::ctx_index(gen_prev_ff, gen_cur_ff), 5'd0);
                  state_in  = twms_pkg::ST_TOT_RD;
               end
               default: begin
               end
            endcase
         end

         twms_pkg::ST_CNT_RD: begin
            state_in = twms_pkg::ST_CNT_WR;
         end

         twms_pkg::ST_CNT_WR: begin
            state_in = twms_pkg::ST_FINISH;
         end

         twms_pkg::ST_TOT_RD: begin
            state_in = twms_pkg::ST_TOT_CHK;
         end

         twms_pkg::ST_TOT_CHK: begin
            if (tot_rd_ff == '0) begin
               res_status_in = twms_pkg::STS_EMPTY;
               res_pos_in    = word_len_ff;
               state_in      = twms_pkg::ST_FINISH;
            end else begin
               div_in     = tot_rd_ff;
               rem_in     = '0;
               div_cnt_in = 5'd0;
               state_in   = twms_pkg::ST_DIV;
            end
         end

         twms_pkg::ST_DIV: begin
            if (rem_shift >= {1'b0, div_ff}) begin
               rem_in = COUNT_BITS'(rem_shift - {1'b0, div_ff});
            end else begin
               rem_in = rem_shift[COUNT_BITS-1:0];
            end
            rnd_in     = {rnd_ff[30:0], 1'b0};
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'd31) begin
               acc_in      = '0;
               walk_k_in   = 5'd0;
               walk_vld_in = 1'b0;
               state_in    = twms_pkg::ST_WALK;
            end
         end

         twms_pkg::ST_WALK: begin
            // read of walk_k is issued now; data for chk_k is on tri_rd_ff
            chk_k_in    = walk_k_ff;
            walk_vld_in = 1'b1;
            if (walk_k_ff != twms_pkg::SYM_BOUNDARY) begin
               walk_k_in = walk_k_ff + 5'd1;
            end
            if (walk_vld_ff) begin
               acc_in = acc_sum[COUNT_BITS-1:0];
               if (walk_hit) begin
                  sym_in   = chk_k_ff;
                  state_in = twms_pkg::ST_APPLY;
               end
            end
         end

         twms_pkg::ST_APPLY: begin
            res_letter_in = 5'd0;
            res_pos_in    = 4'd0;
            if (sym_ff == twms_pkg::SYM_BOUNDARY) begin
               if ((word_len_ff < min_len_ff) || (vowel_cnt_ff == 4'd0)) begin
                  try_cnt_in = try_next;
                  if (try_next < max_tries_ff) begin
                     res_status_in = twms_pkg::STS_RETRY;
                     res_pos_in    = word_len_ff;
                  end else begin
                     res_status_in = twms_pkg::STS_RESTARTED;
                     gen_prev_in   = twms_pkg::SYM_BOUNDARY;
                     gen_cur_in    = twms_pkg::SYM_BOUNDARY;
                     word_len_in   = 4'd0;
                     vowel_cnt_in  = 4'd0;
                     try_cnt_in    = 4'd0;
                  end
               end else begin
                  res_status_in = twms_pkg::STS_COMPLETE;
                  res_pos_in    = word_len_ff;
                  gen_prev_in   = twms_pkg::SYM_BOUNDARY;
                  gen_cur_in    = twms_pkg::SYM_BOUNDARY;
                  word_len_in   = 4'd0;
                  vowel_cnt_in  = 4'd0;
                  try_cnt_in    = 4'd0;
               end
            end else if (word_len_ff >= max_len_ff) begin
               res_status_in = twms_pkg::STS_RESTARTED;
               gen_prev_in   = twms_pkg::SYM_BOUNDARY;
               gen_cur_in    = twms_pkg::SYM_BOUNDARY;
               word_len_in   = 4'd0;
               vowel_cnt_in  = 4'd0;
               try_cnt_in    = 4'd0;
            end else begin
               res_status_in = twms_pkg::STS_LETTER;
               res_letter_in = sym_ff;
               res_pos_in    = word_len_ff;
               if (twms_pkg::is_vowel(sym_ff) && (vowel_cnt_ff != 4'd15)) begin
                  vowel_cnt_in = vowel_cnt_ff + 4'd1;
               end
               word_len_in = word_len_ff + 4'd1;
               gen_prev_in = gen_cur_ff;
               gen_cur_in  = sym_ff;
            end
            state_in = twms_pkg::ST_FINISH;
         end

         twms_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_letter_in = res_letter_ff;
               rsp_pos_in    = res_pos_ff;
               state_in      = twms_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = twms_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= twms_pkg::ST_CLEAR;
         min_len_ff    <= twms_pkg::MIN_LENGTH_RST;
         max_len_ff    <= twms_pkg::MAX_LENGTH_RST;
         max_tries_ff  <= twms_pkg::MAX_TRIES_RST;
         learn_prev_ff <= twms_pkg::SYM_BOUNDARY;
         learn_cur_ff  <= twms_pkg::SYM_BOUNDARY;
         in_word_ff    <= 1'b0;
         gen_prev_ff   <= twms_pkg::SYM_BOUNDARY;
         gen_cur_ff    <= twms_pkg::SYM_BOUNDARY;
         word_len_ff   <= 4'd0;
         vowel_cnt_ff  <= 4'd0;
         try_cnt_ff    <= 4'd0;
         rsp_valid_ff  <= 1'b0;
         clr_addr_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         min_len_ff    <= min_len_in;
         max_len_ff    <= max_len_in;
         max_tries_ff  <= max_tries_in;
         learn_prev_ff <= learn_prev_in;
         learn_cur_ff  <= learn_cur_in;
         in_word_ff    <= in_word_in;
         gen_prev_ff   <= gen_prev_in;
         gen_cur_ff    <= gen_cur_in;
         word_len_ff   <= word_len_in;
         vowel_cnt_ff  <= vowel_cnt_in;
         try_cnt_ff    <= try_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      byte_ff       <= byte_in;
      rnd_ff        <= rnd_in;
      ev_ctx_ff     <= ev_ctx_in;
      ev_tri_ff     <= ev_tri_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      div_cnt_ff    <= div_cnt_in;
      acc_ff        <= acc_in;
      walk_k_ff     <= walk_k_in;
      chk_k_ff      <= chk_k_in;
      walk_vld_ff   <= walk_vld_in;
      sym_ff        <= sym_in;
      res_status_ff <= res_status_in;
      res_letter_ff <= res_letter_in;
      res_pos_ff    <= res_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_letter_ff <= rsp_letter_in;
      rsp_pos_ff    <= rsp_pos_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'd0, rsp_pos_ff, rsp_letter_ff};

endmodule

// ===== src/twms_checker.sv =====
// Port-level assertions for the trigram word sampler, bound to the top level.
`timescale 1ns / 1ps

module twms_port_props (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   // a stalled response transaction holds its content
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // the clearing pass follows every reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during memory clear");

   // letter field only carries data with a letter status, and then a real letter
   a_letter_field: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == twms_pkg::STS_LETTER) ?
                     (rsp_tdata[4:0] <= 5'd25) : (rsp_tdata[4:0] == 5'd0))
      else $error("letter field inconsistent with status");

   // ack and restart report no position
   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tuser == twms_pkg::STS_ACK) ||
                     (rsp_tuser == twms_pkg::STS_RESTARTED)) |-> rsp_tdata[8:5] == 4'd0)
      else $error("position set on ack or restart");

   // padding bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:9] == 7'd0)
      else $error("response padding not zero");

endmodule

bind trigram_word_model_sampler_top twms_port_props u_twms_port_props (.*);

// ===== bench/twms_checker.sv =====
// Response predictor and scoreboard for the trigram word sampler.
`timescale 1ns / 1ps

module twms_checker #(
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // [7:0] text_byte, [39:8] random_value
   input  logic [1:0]  req_tuser,   // [1:0] action
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [4:0] letter, [8:5] position, rest zero
   input  logic [2:0]  rsp_tuser,   // [2:0] status
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_wdata,
   output int          mismatches,
   output int          pending,
   output int          letters_seen,
   output int          words_seen,
   output int          retries_seen,
   output int          restarts_seen,
   output int          empties_seen
);

   typedef struct packed {
      logic [2:0] status;
      logic [4:0] letter;
      logic [3:0] position;
   } word_rsp_type;

   localparam logic [31:0] COUNT_CEIL = 32'((64'd1 << COUNT_BITS) - 1);

   logic [31:0]  tri_cnt [twms_pkg::TRI_DEPTH];
   logic [31:0]  ctx_sum [twms_pkg::CTX_DEPTH];
   logic [4:0]   lrn_prev, lrn_cur;
   logic         lrn_open;
   logic [4:0]   drw_prev, drw_cur;
   logic [3:0]   drw_len, drw_vowels, drw_tries;
   logic [3:0]   cfg_min_len, cfg_max_len, cfg_max_tries;
   word_rsp_type awaited_rsp [$];

   initial begin
      mismatches    = 0;
      pending       = 0;
      letters_seen  = 0;
      words_seen    = 0;
      retries_seen  = 0;
      restarts_seen = 0;
      empties_seen  = 0;
   end

   // a full context row drops the event, so row counts always sum to the total
   task automatic bump_count(input logic [4:0] p, input logic [4:0] c, input logic [4:0] n);
      int ctx;
      ctx = int'(p) * twms_pkg::SYMS + int'(c);
      if (ctx_sum[ctx] < COUNT_CEIL) begin
         ctx_sum[ctx] = ctx_sum[ctx] + 1;
         tri_cnt[ctx * twms_pkg::SYMS + int'(n)] = tri_cnt[ctx * twms_pkg::SYMS + int'(n)] + 1;
      end
   endtask

   task automatic restart_word();
      drw_prev   = twms_pkg::SYM_BOUNDARY;
      drw_cur    = twms_pkg::SYM_BOUNDARY;
      drw_len    = '0;
      drw_vowels = '0;
      drw_tries  = '0;
   endtask

   task automatic close_learned_word();
      if (lrn_open) begin
         bump_count(lrn_prev, lrn_cur, twms_pkg::SYM_BOUNDARY);
         lrn_open = 1'b0;
      end
      lrn_prev = twms_pkg::SYM_BOUNDARY;
      lrn_cur  = twms_pkg::SYM_BOUNDARY;
   endtask

   task automatic predict_word_step(input logic [1:0] act, input logic [7:0] txt,
                                    input logic [31:0] rnd, output word_rsp_type r);
      logic [7:0]  folded;
      logic [4:0]  sym;
      logic [31:0] total, pick;
      logic [63:0] acc;
      logic        found;
      int          ctx;
      r = '0;
      r.status = twms_pkg::STS_ACK;
      case (act)
         twms_pkg::ACT_LEARN: begin
            folded = txt | 8'h20;
            if (folded >= 8'h61 && folded <= 8'h7A && !txt[7]) begin
               sym = 5'(folded - 8'h61);
               if (!lrn_open) begin
                  lrn_prev = twms_pkg::SYM_BOUNDARY;
                  lrn_cur  = twms_pkg::SYM_BOUNDARY;
                  lrn_open = 1'b1;
               end
               bump_count(lrn_prev, lrn_cur, sym);
               lrn_prev = lrn_cur;
               lrn_cur  = sym;
            end else begin
               close_learned_word();
            end
         end
         twms_pkg::ACT_END_TEXT: close_learned_word();
         twms_pkg::ACT_START:    restart_word();
         default: begin
            ctx   = int'(drw_prev) * twms_pkg::SYMS + int'(drw_cur);
            total = ctx_sum[ctx];
            if (total == 0) begin
               r.status   = twms_pkg::STS_EMPTY;
               r.position = drw_len;
            end else begin
               pick  = rnd % total;
               acc   = '0;
               sym   = twms_pkg::SYM_BOUNDARY;
               found = 1'b0;
               for (int k = 0; k < twms_pkg::SYMS; k++) begin
                  if (!found) begin
                     acc = acc + 64'(tri_cnt[ctx * twms_pkg::SYMS + k]);
                     if (acc > 64'(pick)) begin
                        sym   = 5'(k);
                        found = 1'b1;
                     end
                  end
               end
               if (sym == twms_pkg::SYM_BOUNDARY) begin
                  if (drw_len < cfg_min_len || drw_vowels == 0) begin
                     drw_tries = drw_tries + 4'd1;
                     if (drw_tries < cfg_max_tries) begin
                        r.status   = twms_pkg::STS_RETRY;
                        r.position = drw_len;
                     end else begin
                        restart_word();
                        r.status = twms_pkg::STS_RESTARTED;
                     end
                  end else begin
                     r.status   = twms_pkg::STS_COMPLETE;
                     r.position = drw_len;
                     restart_word();
                  end
               end else if (drw_len >= cfg_max_len) begin
                  restart_word();
                  r.status = twms_pkg::STS_RESTARTED;
               end else begin
                  r.status   = twms_pkg::STS_LETTER;
                  r.letter   = sym;
                  r.position = drw_len;
                  // a, e, i, o, u
                  if ((sym == 5'd0 || sym == 5'd4 || sym == 5'd8 || sym == 5'd14 ||
                       sym == 5'd20) && drw_vowels != 4'd15)
                     drw_vowels = drw_vowels + 4'd1;
                  drw_len  = drw_len + 4'd1;
                  drw_prev = drw_cur;
                  drw_cur  = sym;
               end
            end
         end
      endcase
   endtask

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: mismatch: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin : monitor
      word_rsp_type seen, want;
      if (reset) begin
         for (int i = 0; i < twms_pkg::TRI_DEPTH; i++) tri_cnt[i] = '0;
         for (int i = 0; i < twms_pkg::CTX_DEPTH; i++) ctx_sum[i] = '0;
         lrn_prev      = twms_pkg::SYM_BOUNDARY;
         lrn_cur       = twms_pkg::SYM_BOUNDARY;
         lrn_open      = 1'b0;
         restart_word();
         cfg_min_len   = twms_pkg::MIN_LENGTH_RST;
         cfg_max_len   = twms_pkg::MAX_LENGTH_RST;
         cfg_max_tries = twms_pkg::MAX_TRIES_RST;
         awaited_rsp.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               twms_pkg::CSR_MIN_LENGTH: cfg_min_len   = csr_wdata;
               twms_pkg::CSR_MAX_LENGTH: cfg_max_len   = csr_wdata;
               twms_pkg::CSR_MAX_TRIES:  cfg_max_tries = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.status   = rsp_tuser;
            seen.letter   = rsp_tdata[4:0];
            seen.position = rsp_tdata[8:5];
            case (seen.status)
               twms_pkg::STS_LETTER:    letters_seen++;
               twms_pkg::STS_COMPLETE:  words_seen++;
               twms_pkg::STS_RETRY:     retries_seen++;
               twms_pkg::STS_RESTARTED: restarts_seen++;
               twms_pkg::STS_EMPTY:     empties_seen++;
               default: ;
            endcase
            if (awaited_rsp.size() == 0) begin
               report_mismatch($sformatf("response with nothing outstanding: status %0d",
                                         seen.status));
            end else begin
               want = awaited_rsp.pop_front();
               if (seen.status !== want.status || seen.letter !== want.letter ||
                   seen.position !== want.position || rsp_tdata[15:9] !== '0)
                  report_mismatch($sformatf(
                     {"expected status %0d letter %0d pos %0d, ",
                      "got status %0d letter %0d pos %0d pad %h"},
                     want.status, want.letter, want.position,
                     seen.status, seen.letter, seen.position, rsp_tdata[15:9]));
            end
         end
         if (req_tvalid && req_tready) begin
            predict_word_step(req_tuser, req_tdata[7:0], req_tdata[39:8], want);
            awaited_rsp = {awaited_rsp, want};
         end
      end
      pending = awaited_rsp.size();
   end

endmodule

// ===== bench/tb.sv =====
// Testbench top: stimulus, handshake pacing and verdict for the trigram word sampler.
`timescale 1ns / 1ps

module tb;

   localparam int COUNT_BITS     = 16;
   localparam int RANDOM_ITEMS   = 900;
   // learn transactions that pile up in the (q, q) context
   localparam int Q_RUN          = 40;
   // covers the clearing pass after reset several times over
   localparam int WATCHDOG_LIMIT = 80000;
   localparam int TAIL_CYCLES    = 80;
   // index the block must ignore
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;    // [7:0] text_byte, [39:8] random_value
   logic [1:0]  req_tuser  = '0;    // [1:0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [4:0] letter, [8:5] position, rest zero
   logic [2:0]  rsp_tuser;          // [2:0] status
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = '0;
   logic [3:0]  csr_wdata  = '0;

   int mismatches, pending;
   int letters_seen, words_seen, retries_seen, restarts_seen, empties_seen;

   int   items_sent    = 0;
   int   settings_used = 0;
   int   quiet_cycles  = 0;
   logic idle_on       = 1'b1;      // shared by both sides: random gaps and stalls
   logic [7:0] primer_text [17];

   trigram_word_model_sampler_top #(
      .COUNT_BITS (COUNT_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   twms_checker #(
      .COUNT_BITS (COUNT_BITS)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .pending       (pending),
      .letters_seen  (letters_seen),
      .words_seen    (words_seen),
      .retries_seen  (retries_seen),
      .restarts_seen (restarts_seen),
      .empties_seen  (empties_seen)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Request transaction: optional gap with tvalid low, then hold until tready.
   // Inputs move on the falling edge only; a zero gap keeps tvalid high across items.
   task automatic send_req(input logic [1:0] act, input logic [7:0] txt,
                           input logic [31:0] rnd);
      int gap;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = act;
      req_tdata  = {rnd, txt};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Sender holds off until every outstanding transaction has its response.
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      wait (pending == 0);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [3:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // only called with the block drained
   task automatic set_limits(input logic [3:0] min_len, input logic [3:0] max_len,
                             input logic [3:0] max_tries);
      write_csr(twms_pkg::CSR_MIN_LENGTH, min_len);
      write_csr(twms_pkg::CSR_MAX_LENGTH, max_len);
      write_csr(twms_pkg::CSR_MAX_TRIES, max_tries);
      settings_used++;
   endtask

   // Response side: random stall before each response, tready held until one is taken.
   initial begin : rsp_side
      int stall;
      wait (!reset);
      forever begin
         @(negedge clock);
         stall = idle_on ? $urandom_range(0, 7) : 0;
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Watchdog: any accepted transaction on either channel resets the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      int          random_goal, chunk_end, phase, kind, n, len;
      logic [4:0]  idx;
      logic [7:0]  ch, sep;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- Directed part, reset limits (min 5, max 9, tries 10) ----
      // Draw before anything is learned: empty context.
      send_req(twms_pkg::ACT_DRAW, 8'h00, 32'h0000_0000);
      // End of text with no open word only acks.
      send_req(twms_pkg::ACT_END_TEXT, 8'h00, 32'h0);
      // Mixed case words, letter range ends, closers on both sides of the
      // letter ranges, a zero byte and a byte with the top bit set.
      primer_text = '{"Z", "e", "b", "r", "a", 8'hFF, "A", "z", "u", "l",
                      8'h40, 8'h5B, 8'h60, 8'h7B, 8'h00, "O", "k"};
      foreach (primer_text[i]) send_req(twms_pkg::ACT_LEARN, primer_text[i], $urandom);
      // closes the open word "ok" through end of text
      send_req(twms_pkg::ACT_END_TEXT, 8'hFF, 32'h0);
      send_req(twms_pkg::ACT_START, 8'h00, 32'h0);
      send_req(twms_pkg::ACT_DRAW, 8'h00, 32'hFFFF_FFFF);
      send_req(twms_pkg::ACT_DRAW, 8'hFF, 32'h0000_0000);
      send_req(twms_pkg::ACT_DRAW, 8'h00, $urandom);
      send_req(twms_pkg::ACT_DRAW, 8'h00, $urandom);
      drain();
      // unused register index must change nothing
      write_csr(CSR_UNUSED, 4'($urandom_range(0, 15)));

      // ---- One long q word at full rate: context (q, q) mostly repeats q ----
      idle_on = 1'b0;
      repeat (Q_RUN) send_req(twms_pkg::ACT_LEARN, "q", 32'h0);
      send_req(twms_pkg::ACT_LEARN, 8'h20, 32'h0);
      drain();
      set_limits(4'd5, 4'd15, 4'd10);
      idle_on = 1'b1;
      // Words that reach q tend to stay on q until the length limit restarts them.
      repeat (8) begin
         send_req(twms_pkg::ACT_START, 8'h00, 32'h0);
         repeat (18) send_req(twms_pkg::ACT_DRAW, 8'h00, $urandom);
      end

      // ---- Random part: phases of limits, each a mix of episodes ----
      random_goal = items_sent + RANDOM_ITEMS;
      phase = 0;
      while (items_sent < random_goal) begin
         drain();
         case (phase)
            0: set_limits(4'd0, 4'd0, 4'd0);
            1: set_limits(4'd15, 4'd15, 4'd15);
            2: set_limits(4'd1, 4'd15, 4'd1);
            3: set_limits(4'd0, 4'd15, 4'd0);
            4: set_limits(4'd3, 4'd6, 4'd2);
            5: set_limits(4'd15, 4'd1, 4'd15);
            6: set_limits(4'd2, 4'd12, 4'd8);
            default: set_limits(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                4'($urandom_range(0, 15)));
         endcase
         // every fourth phase runs at full rate on both sides
         idle_on   = (phase % 4) != 3;
         chunk_end = items_sent + $urandom_range(60, 120);
         while (items_sent < chunk_end) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
               // learn text: vowel-heavy words, random case, non-letter separators
               n = $urandom_range(1, 6);
               repeat (n) begin
                  len = $urandom_range(1, 14);
                  repeat (len) begin
                     if ($urandom_range(0, 9) < 4)
                        case ($urandom_range(0, 4))
                           0: idx = 5'd0;
                           1: idx = 5'd4;
                           2: idx = 5'd8;
                           3: idx = 5'd14;
                           default: idx = 5'd20;
                        endcase
                     else
                        idx = 5'($urandom_range(0, 25));
                     ch = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(idx);
                     send_req(twms_pkg::ACT_LEARN, ch, $urandom);
                  end
                  // some words are left open for end of text to close
                  if ($urandom_range(0, 3) != 0) begin
                     do sep = 8'($urandom_range(0, 255));
                     while ((sep | 8'h20) >= 8'h61 && (sep | 8'h20) <= 8'h7A && !sep[7]);
                     send_req(twms_pkg::ACT_LEARN, sep, $urandom);
                  end
               end
               if ($urandom_range(0, 1))
                  send_req(twms_pkg::ACT_END_TEXT, 8'($urandom_range(0, 255)), $urandom);
            end else if (kind < 85) begin
               // draw a word, now and then continuing the previous one
               if ($urandom_range(0, 9) != 0)
                  send_req(twms_pkg::ACT_START, 8'($urandom_range(0, 255)), $urandom);
               repeat ($urandom_range(1, 20))
                  send_req(twms_pkg::ACT_DRAW, 8'($urandom_range(0, 255)), $urandom);
            end else if (kind < 95) begin
               // noise: any action, any payload
               repeat ($urandom_range(1, 4))
                  send_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), $urandom);
            end else begin
               drain();
            end
         end
         phase++;
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d transactions over %0d limit settings, incl. a %0d-letter q run.",
               items_sent, settings_used, Q_RUN);
      $display("Responses: %0d letters, %0d words, %0d retries, %0d restarts, %0d empty contexts.",
               letters_seen, words_seen, retries_seen, restarts_seen, empties_seen);
      if (mismatches == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/twms_pkg.sv
src/trigram_word_model_sampler_top.sv
src/twms_checker.sv
bench/twms_checker.sv
bench/tb.sv
